@@ rtl/sha1_stream_hasher_macros.svh @@
// assertion macros for the checker file of the sha-1 stream hasher
// no dependencies; included by bare file name
`ifndef SHA1_STREAM_HASHER_MACROS_SVH
`define SHA1_STREAM_HASHER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SHA1_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha1 check failed");

// next-cycle implication, disabled while reset is asserted
`define SHA1_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha1 check failed");

`endif

@@ rtl/sha1_pkg.sv @@
// shared constants, types and round functions of the sha-1 stream hasher
// no dependencies; used by the controller, the datapath and the top level
`default_nettype none

package sha1_pkg;

    localparam int FILL_W   = 6;
    localparam int LEN_W    = 61;
    localparam int CNT_W    = 7;
    localparam int IDX_W    = 3;
    localparam int NUM_WRDS = 5;

    localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
    localparam logic [FILL_W-1:0] FILL_LEN  = 6'd56;
    localparam logic [CNT_W-1:0]  RND_LAST  = 7'd79;
    localparam logic [IDX_W-1:0]  LEN_LAST  = 3'd7;
    localparam logic [IDX_W-1:0]  WRD_LAST  = 3'd4;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] H_INIT [NUM_WRDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    // source of the byte shifted into the block window
    typedef enum logic [1:0] {
        BSEL_IN,
        BSEL_PAD,
        BSEL_ZERO,
        BSEL_LEN
    } t_byte_sel;

    // round group: 0..19, 20..39, 40..59, 60..79
    typedef enum logic [1:0] {
        PH_CH,
        PH_PAR1,
        PH_MAJ,
        PH_PAR2
    } t_phase;

    typedef struct packed {
        logic             push;
        t_byte_sel        bsel;
        logic [IDX_W-1:0] idx;
        logic             count;
        logic             load;
        logic             round;
        logic [CNT_W-1:0] round_idx;
        logic             finish;
        logic             init;
    } t_dp_cmd;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
    } t_dp_sts;

    function automatic t_phase sha1_phase(input logic [CNT_W-1:0] t);
        t_phase ph;
        if (t < 7'd20) begin
            ph = PH_CH;
        end else if (t < 7'd40) begin
            ph = PH_PAR1;
        end else if (t < 7'd60) begin
            ph = PH_MAJ;
        end else begin
            ph = PH_PAR2;
        end
        return ph;
    endfunction

    function automatic logic [31:0] sha1_f(input t_phase ph, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        unique case (ph)
            PH_CH:   f = (b & c) | (~b & d);
            PH_MAJ:  f = (b & c) | (b & d) | (c & d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

    function automatic logic [31:0] sha1_k(input t_phase ph);
        logic [31:0] k;
        unique case (ph)
            PH_CH:   k = K_0;
            PH_PAR1: k = K_1;
            PH_MAJ:  k = K_2;
            default: k = K_3;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

@@ rtl/sha1_if.sv @@
// valid/ready channel interfaces for message bytes and digest words
// no dependencies
`default_nettype none

interface sha1_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;

    modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
    modport sink   (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface sha1_dig_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

@@ rtl/sha1_dp.sv @@
// sha-1 datapath: chaining words, 512-bit block window, round logic, counters
// depends on sha1_pkg
`default_nettype none

module sha1_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sha1_pkg::t_dp_cmd            i_cmd,
    input  logic [7:0]                   i_data_byte,
    output sha1_pkg::t_dp_sts            o_sts,
    output logic [31:0]                  o_digest_word
);
    import sha1_pkg::*;

    logic [31:0]       r_h [NUM_WRDS];
    logic [31:0]       r_a, r_b, r_c, r_d, r_e;
    logic [511:0]      r_win;
    logic [FILL_W-1:0] r_fill;
    logic [LEN_W-1:0]  r_len;

    logic [63:0]  w_bits;
    logic [5:0]   w_sh;
    logic [7:0]   w_len_byte;
    logic [7:0]   w_byte;
    logic [31:0]  w_w0;
    logic [31:0]  w_sched;
    logic [31:0]  w_nx;
    t_phase       w_ph;

    // big-endian bit length, byte idx 0 first
    assign w_bits     = {r_len, 3'b000};
    assign w_sh       = {~i_cmd.idx, 3'b000};
    assign w_len_byte = w_bits[w_sh +: 8];

    always_comb begin
        unique case (i_cmd.bsel)
            BSEL_IN:   w_byte = i_data_byte;
            BSEL_PAD:  w_byte = PAD_BYTE;
            BSEL_ZERO: w_byte = 8'h00;
            BSEL_LEN:  w_byte = w_len_byte;
        endcase
    end

    // message schedule taps: w[t], w[t+2], w[t+8], w[t+13]
    assign w_w0    = r_win[511:480];
    assign w_sched = {w_w0 ^ r_win[447:416] ^ r_win[255:224] ^ r_win[95:64]} << 1
                   | {31'd0, w_w0[31] ^ r_win[447] ^ r_win[255] ^ r_win[95]};

    // one compression round
    assign w_ph = sha1_phase(i_cmd.round_idx);
    assign w_nx = {r_a[26:0], r_a[31:27]} + sha1_f(w_ph, r_b, r_c, r_d)
                + r_e + sha1_k(w_ph) + w_w0;

    // chaining words and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WRDS; i++) begin
                r_h[i] <= H_INIT[i];
            end
            r_fill <= '0;
            r_len  <= '0;
        end else if (i_cmd.init) begin
            for (int i = 0; i < NUM_WRDS; i++) begin
                r_h[i] <= H_INIT[i];
            end
            r_fill <= '0;
            r_len  <= '0;
        end else begin
            if (i_cmd.finish) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
            if (i_cmd.push) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.count) begin
                r_len <= r_len + 61'd1;
            end
        end
    end

    // block window and working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_win <= {r_win[503:0], w_byte};
        end else if (i_cmd.round) begin
            r_win <= {r_win[479:0], w_sched};
        end
        if (i_cmd.load) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_cmd.round) begin
            r_a <= w_nx;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    assign o_sts.fill    = r_fill;
    assign o_digest_word = r_h[i_cmd.idx];

endmodule

`default_nettype wire

@@ rtl/sha1_ctrl.sv @@
// sha-1 controller: byte intake, padding sequence, round count, digest output
// depends on sha1_pkg
`default_nettype none

module sha1_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_byte_valid,
    input  logic                         i_end_of_message,
    output logic                         o_in_ready,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [sha1_pkg::IDX_W-1:0]   o_word_index,
    output logic                         o_last_word,
    input  sha1_pkg::t_dp_sts            i_sts,
    output sha1_pkg::t_dp_cmd            o_cmd
);
    import sha1_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_ZERO = 3'd2;
    localparam logic [2:0] ST_LEN  = 3'd3;
    localparam logic [2:0] ST_COMP = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [2:0]       r_ret,   n_ret;
    logic [CNT_W-1:0] r_cnt,   n_cnt;
    logic             w_full;

    assign w_full = (i_sts.fill == FILL_LAST);

    // next state and datapath commands
    always_comb begin
        n_state         = r_state;
        n_ret           = r_ret;
        n_cnt           = r_cnt;
        o_cmd           = '0;
        o_cmd.bsel      = BSEL_IN;
        o_cmd.idx       = r_cnt[IDX_W-1:0];
        o_cmd.round_idx = r_cnt;
        o_in_ready      = 1'b0;
        o_out_valid     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_byte_valid) begin
                        o_cmd.push  = 1'b1;
                        o_cmd.count = 1'b1;
                    end
                    if (i_byte_valid && w_full) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_COMP;
                        n_cnt      = '0;
                        n_ret      = i_end_of_message ? ST_PAD : ST_IDLE;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                o_cmd.push = 1'b1;
                o_cmd.bsel = BSEL_PAD;
                if (w_full) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_COMP;
                    n_cnt      = '0;
                    n_ret      = ST_ZERO;
                end else begin
                    n_state = ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (i_sts.fill == FILL_LEN) begin
                    n_state = ST_LEN;
                    n_cnt   = '0;
                end else begin
                    o_cmd.push = 1'b1;
                    o_cmd.bsel = BSEL_ZERO;
                    if (w_full) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_COMP;
                        n_cnt      = '0;
                        n_ret      = ST_ZERO;
                    end
                end
            end
            ST_LEN: begin
                o_cmd.push = 1'b1;
                o_cmd.bsel = BSEL_LEN;
                n_cnt      = r_cnt + 7'd1;
                // last length byte always closes the block
                if (r_cnt[IDX_W-1:0] == LEN_LAST) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_COMP;
                    n_cnt      = '0;
                    n_ret      = ST_EMIT;
                end
            end
            ST_COMP: begin
                o_cmd.round = 1'b1;
                n_cnt       = r_cnt + 7'd1;
                if (r_cnt == RND_LAST) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = r_ret;
                n_cnt        = '0;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_cnt[IDX_W-1:0] == WRD_LAST) begin
                        o_cmd.init = 1'b1;
                        n_state    = ST_IDLE;
                        n_cnt      = '0;
                    end else begin
                        n_cnt = r_cnt + 7'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_cnt   <= n_cnt;
        end
    end

    assign o_word_index = r_cnt[IDX_W-1:0];
    assign o_last_word  = (r_cnt[IDX_W-1:0] == WRD_LAST);

endmodule

`default_nettype wire

@@ rtl/sha1_stream_hasher.sv @@
// sha-1 stream hasher top level: joins controller and datapath to the channels
// depends on sha1_pkg, sha1_if, sha1_ctrl, sha1_dp
//
//  channel  dir  payload                                   transfer
//  i_msg    in   data_byte[7:0] byte_valid end_of_message  valid & ready
//  o_dig    out  digest_word[31:0] word_index[2:0] last_word valid & ready
//
// a full 64-byte block runs 80 rounds on the single round unit, then folds
// into the chaining words; an end item pads one byte per cycle, paused
// while a block compresses, to byte 56 (then a check step), appends 8
// length bytes and compresses (twice if the pad crosses a block)
// 5 digest words follow, one per cycle while o_dig.ready stays high
// sync active-low reset; no bytes taken while busy or while words wait
`default_nettype none

module sha1_stream_hasher (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sha1_msg_if.sink          i_msg,
    sha1_dig_if.source        o_dig
);
    import sha1_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    sha1_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_msg.valid),
        .i_byte_valid     (i_msg.byte_valid),
        .i_end_of_message (i_msg.end_of_message),
        .o_in_ready       (i_msg.ready),
        .o_out_valid      (o_dig.valid),
        .i_out_ready      (o_dig.ready),
        .o_word_index     (o_dig.word_index),
        .o_last_word      (o_dig.last_word),
        .i_sts            (w_sts),
        .o_cmd            (w_cmd)
    );

    sha1_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_data_byte   (i_msg.data_byte),
        .o_sts         (w_sts),
        .o_digest_word (o_dig.digest_word)
    );

endmodule

`default_nettype wire

@@ rtl/sha1_chk.sv @@
// port-level checker for the sha-1 stream hasher, bound to the top level
// depends on sha1_stream_hasher_macros.svh and sha1_stream_hasher
`default_nettype none
`include "sha1_stream_hasher_macros.svh"

module sha1_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_digest_word,
    input logic [2:0]  i_word_index,
    input logic        i_last_word
);

    logic        w_stall;
    logic        w_mid;
    logic [2:0]  w_nidx;
    logic [34:0] w_out_pl;

    // handshake conditions and the payload as one vector
    assign w_stall  = i_out_valid && !i_out_ready;
    assign w_mid    = i_out_valid && i_out_ready && !i_last_word;
    assign w_nidx   = i_word_index + 3'd1;
    assign w_out_pl = {i_digest_word, i_word_index};

    // a stalled digest word holds
    `SHA1_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_stall, i_out_valid && $stable(w_out_pl))

    // last flag marks exactly the fifth word
    `SHA1_ASSERT_IMP(a_last_idx, i_clk, i_rst_n, i_out_valid, i_last_word == (i_word_index == 3'd4))

    // words of one digest follow each other in order
    `SHA1_ASSERT_NXT(a_idx_step, i_clk, i_rst_n, w_mid, i_out_valid && i_word_index == $past(w_nidx))

    // no bytes are taken while a digest is being delivered
    `SHA1_ASSERT_IMP(a_no_intake, i_clk, i_rst_n, i_out_valid, !i_in_ready)

endmodule

bind sha1_stream_hasher sha1_chk u_sha1_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_msg.ready),
    .i_out_valid   (o_dig.valid),
    .i_out_ready   (o_dig.ready),
    .i_digest_word (o_dig.digest_word),
    .i_word_index  (o_dig.word_index),
    .i_last_word   (o_dig.last_word)
);

`default_nettype wire

@@ tb/sha1_stream_hasher_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the sha-1 stream hasher: directed table, then random messages
// depends on sha1_if (message and digest channels) and the sha1_stream_hasher top level
module sha1_stream_hasher_tb;

    localparam int  N_RANDOM_BYTES = 270;
    localparam int  CYCLE_LIMIT    = 400000;
    localparam int  DRAIN_CYCLES   = 250;
    localparam int  N_DIRECTED     = 16;

    localparam logic [159:0] DG_EMPTY = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
    localparam logic [159:0] DG_ABC   = 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

    typedef struct packed {
        logic [7:0]   data;
        logic         byte_ok;
        logic         eom;
        logic         known;
        logic [159:0] digest;
    } t_stim_row;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        is_last;
    } t_digest_out;

    // directed rows: empty message, "abc", noise items, byte extremes
    localparam t_stim_row DIR_TABLE [N_DIRECTED] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, DG_EMPTY},
        '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'hff, 1'b0, 1'b0, 1'b0, 160'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h63, 1'b1, 1'b1, 1'b1, DG_ABC},
        '{8'h00, 1'b0, 1'b1, 1'b1, DG_EMPTY},
        '{8'h00, 1'b1, 1'b1, 1'b0, 160'h0},
        '{8'hff, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h55, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'haa, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'hff, 1'b0, 1'b1, 1'b0, 160'h0},
        '{8'hff, 1'b1, 1'b1, 1'b0, 160'h0},
        '{8'ha5, 1'b0, 1'b0, 1'b0, 160'h0},
        '{8'h5a, 1'b0, 1'b0, 1'b0, 160'h0},
        '{8'h00, 1'b0, 1'b1, 1'b1, DG_EMPTY}
    };

    // message lengths that put the pad at every block boundary case
    localparam int EDGE_LEN [4] = '{55, 56, 63, 64};

    logic i_clk;
    logic i_rst_n;

    sha1_msg_if msg_if ();
    sha1_dig_if dig_if ();

    sha1_stream_hasher uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (msg_if.sink),
        .o_dig   (dig_if.source)
    );

    // hash state of the predictor
    logic [31:0] hv [5];
    logic [7:0]  blk [64];
    logic [5:0]  fill;
    logic [60:0] nbytes;

    t_digest_out pending_words [$];

    int  mismatch_cnt = 0;
    int  cycles       = 0;
    int  bytes_sent   = 0;
    int  items_sent   = 0;
    int  msgs_done    = 0;
    int  words_seen   = 0;
    bit  tx_calm      = 1'b0;
    bit  rx_calm      = 1'b0;
    int  rx_hold      = 0;

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0d] MISMATCH: %s", cycles, msg);
        mismatch_cnt++;
    endtask

    // predictor
    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void init_hash();
        hv[0]  = 32'h67452301;
        hv[1]  = 32'hefcdab89;
        hv[2]  = 32'h98badcfe;
        hv[3]  = 32'h10325476;
        hv[4]  = 32'hc3d2e1f0;
        fill   = '0;
        nbytes = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, nx;
        int t;
        for (t = 0; t < 16; t++) begin
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        end
        for (t = 16; t < 80; t++) begin
            w[t] = rotl(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
        end
        a = hv[0];
        b = hv[1];
        c = hv[2];
        d = hv[3];
        e = hv[4];
        for (t = 0; t < 80; t++) begin
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = 32'h5a827999;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = 32'h6ed9eba1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8f1bbcdc;
            end else begin
                f = b ^ c ^ d;
                k = 32'hca62c1d6;
            end
            nx = rotl(a, 5) + f + e + k + w[t];
            e  = d;
            d  = c;
            c  = rotl(b, 30);
            b  = a;
            a  = nx;
        end
        hv[0] += a;
        hv[1] += b;
        hv[2] += c;
        hv[3] += d;
        hv[4] += e;
    endfunction

    function automatic void absorb_byte(input logic [7:0] v);
        blk[fill] = v;
        if (fill == 6'd63) begin
            compress_block();
            fill = '0;
        end else begin
            fill = fill + 6'd1;
        end
    endfunction

    // one accepted item; done is set when a digest is produced
    function automatic void hash_item(input logic [7:0] data, input logic byte_ok,
                                      input logic eom, output bit done,
                                      output logic [159:0] dg);
        logic [63:0] bitlen;
        int i;
        done = 1'b0;
        dg   = '0;
        if (byte_ok) begin
            absorb_byte(data);
            nbytes = nbytes + 61'd1;
        end
        if (eom) begin
            bitlen = {nbytes, 3'b000};
            absorb_byte(8'h80);
            while (fill != 6'd56) absorb_byte(8'h00);
            for (i = 7; i >= 0; i--) absorb_byte(bitlen[8*i +: 8]);
            dg   = {hv[0], hv[1], hv[2], hv[3], hv[4]};
            done = 1'b1;
            init_hash();
        end
    endfunction

    function automatic void queue_digest(input logic [159:0] dg);
        t_digest_out x;
        int i;
        for (i = 0; i < 5; i++) begin
            x.word    = dg[159-32*i -: 32];
            x.idx     = i[2:0];
            x.is_last = (i == 4);
            pending_words.push_back(x);
        end
    endfunction

    // mostly short gaps, a few long ones, none in calm stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (tx_calm || r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // drive one item and hold it until the transfer, then predict
    task automatic send_item(input logic [7:0] data, input logic byte_ok, input logic eom,
                             input bit known, input logic [159:0] known_dg);
        bit done;
        logic [159:0] dg;
        int gap;
        msg_if.valid          <= 1'b1;
        msg_if.data_byte      <= data;
        msg_if.byte_valid     <= byte_ok;
        msg_if.end_of_message <= eom;
        do @(posedge i_clk); while (!msg_if.ready);
        items_sent++;
        if (byte_ok) bytes_sent++;
        hash_item(data, byte_ok, eom, done, dg);
        if (done) begin
            queue_digest(known ? known_dg : dg);
            msgs_done++;
        end
        gap = pick_gap();
        if (gap > 0) begin
            msg_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_digests();
        while (pending_words.size() != 0) @(posedge i_clk);
    endtask

    // digest sink: check each transfer, then pick the next ready
    always @(posedge i_clk) begin : dig_sink
        t_digest_out want;
        if (i_rst_n && dig_if.valid && dig_if.ready) begin
            words_seen++;
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h index %0d last %b",
                                          dig_if.digest_word, dig_if.word_index,
                                          dig_if.last_word));
            end else begin
                want = pending_words.pop_front();
                if (dig_if.digest_word !== want.word)
                    report_mismatch($sformatf("digest_word %h, expected %h (index %0d)",
                                              dig_if.digest_word, want.word, want.idx));
                if (dig_if.word_index !== want.idx)
                    report_mismatch($sformatf("word_index %0d, expected %0d",
                                              dig_if.word_index, want.idx));
                if (dig_if.last_word !== want.is_last)
                    report_mismatch($sformatf("last_word %b, expected %b (index %0d)",
                                              dig_if.last_word, want.is_last, want.idx));
            end
        end
        if (rx_hold > 0) begin
            dig_if.ready <= 1'b0;
            rx_hold--;
        end else begin
            dig_if.ready <= 1'b1;
            if (!rx_calm && $urandom_range(0, 5) == 0)
                rx_hold = ($urandom_range(0, 19) < 17) ? $urandom_range(1, 3)
                                                       : $urandom_range(8, 30);
        end
        if ($urandom_range(0, 299) == 0) rx_calm = ~rx_calm;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycles, pending_words.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // stimulus
    initial begin : stim
        int r, len, k;
        bit end_on_byte;
        i_clk                 = 1'b0;
        i_rst_n               = 1'b0;
        msg_if.valid          = 1'b0;
        msg_if.data_byte      = 8'h00;
        msg_if.byte_valid     = 1'b0;
        msg_if.end_of_message = 1'b0;
        dig_if.ready          = 1'b0;
        init_hash();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (r = 0; r < N_DIRECTED; r++) begin
            send_item(DIR_TABLE[r].data, DIR_TABLE[r].byte_ok, DIR_TABLE[r].eom,
                      DIR_TABLE[r].known, DIR_TABLE[r].digest);
        end

        // hold the sender until every digest word is back
        msg_if.valid <= 1'b0;
        wait_for_digests();
        @(posedge i_clk);

        // random messages; the first few hit the padding boundaries
        k = 0;
        while (bytes_sent < N_RANDOM_BYTES + 8) begin
            if (k < 4) begin
                len = EDGE_LEN[k];
            end else if ($urandom_range(0, 5) == 0) begin
                len = $urandom_range(50, 70);
            end else begin
                len = $urandom_range(0, 12);
            end
            tx_calm     = ($urandom_range(0, 3) == 0);
            end_on_byte = (len > 0) && $urandom_range(0, 1);
            for (r = 0; r < len; r++) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
                send_item(8'($urandom_range(0, 255)), 1'b1,
                          end_on_byte && (r == len - 1), 1'b0, '0);
            end
            if (!end_on_byte)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
            if ($urandom_range(0, 7) == 0) begin
                msg_if.valid <= 1'b0;
                wait_for_digests();
                @(posedge i_clk);
            end
            k++;
        end
        msg_if.valid <= 1'b0;

        // drain
        wait_for_digests();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d messages, %0d transfers in (%0d message bytes)",
                 msgs_done, items_sent, bytes_sent);
        $display("checked %0d digest words, %0d mismatches", words_seen, mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ sha1_stream_hasher.f @@
+incdir+rtl
rtl/sha1_pkg.sv
rtl/sha1_if.sv
rtl/sha1_dp.sv
rtl/sha1_ctrl.sv
rtl/sha1_stream_hasher.sv
rtl/sha1_chk.sv
tb/sha1_stream_hasher_tb.sv
